FILE: src/sgf_pkg.sv
// ----------------------------------------------------------------------------
// sgf_pkg: shared types and constants of the sample gap filler
// Holds the command passed from the front to the back, the result status
// codes and the fill mode codes.
// ----------------------------------------------------------------------------
package sgf_pkg;

  localparam int VALUE_W    = 32;
  localparam int GAP_W      = 6;
  localparam int MAX_GAP    = 63;
  localparam int TOTAL_W    = 16;
  localparam int MODE_W     = 2;
  localparam int K_W        = GAP_W + 1;
  localparam int DIVIDEND_W = VALUE_W + GAP_W;
  localparam int DIVISOR_W  = GAP_W + 1;
  localparam int DIV_STEPS  = DIVIDEND_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int LEVEL_W    = PTR_W + 1;

  localparam logic [MODE_W-1:0] MODE_LINEAR = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FWD    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_BWD    = 2'd2;

  typedef enum logic [1:0] {
    ST_ORIG     = 2'd0,
    ST_FILLED   = 2'd1,
    ST_MISSING  = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  // what the back does with the held gap and the closing result
  typedef enum logic [1:0] {
    CMD_PRESENT  = 2'd0,
    CMD_FWD      = 2'd1,
    CMD_END_MISS = 2'd2,
    CMD_OVF      = 2'd3
  } cmd_kind_e;

  typedef struct packed {
    cmd_kind_e          kind;
    logic [MODE_W-1:0]  mode;
    logic [GAP_W-1:0]   gap;
    logic [VALUE_W-1:0] prev;
    logic               have_prev;
    logic [VALUE_W-1:0] next;
    logic               last;
  } cmd_t;

endpackage

FILE: src/sgf_front.sv
// ----------------------------------------------------------------------------
// sgf_front: input side of the sample gap filler
// Accepts samples, tracks the held gap and the last present value, and
// turns each sample into a command for the back, or holds it in the gap.
// ----------------------------------------------------------------------------
module sgf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic [sgf_pkg::MODE_W-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [sgf_pkg::VALUE_W-1:0]  in_value_i,
  input  logic                         in_present_i,
  input  logic                         in_end_i,
  input  logic                         full_i,
  output logic                         push_o,
  output sgf_pkg::cmd_t                cmd_o
);
  import sgf_pkg::*;

  logic [MODE_W-1:0]  fill_mode_q;
  logic [VALUE_W-1:0] last_val_q, last_val_d;
  logic               have_prev_q, have_prev_d;
  logic [GAP_W-1:0]   pend_q, pend_d;
  logic               ovf_q, ovf_d;
  logic [MODE_W-1:0]  mode;
  logic               accept;

  assign in_ready_o = !full_i;
  assign accept     = in_valid_i && !full_i;

  // the unused mode code behaves as linear
  assign mode = (fill_mode_q == MODE_FWD || fill_mode_q == MODE_BWD) ? fill_mode_q
                                                                      : MODE_LINEAR;

  always_comb begin
    cmd_o.kind      = CMD_PRESENT;
    cmd_o.mode      = mode;
    cmd_o.gap       = pend_q;
    cmd_o.prev      = last_val_q;
    cmd_o.have_prev = have_prev_q;
    cmd_o.next      = in_value_i;
    cmd_o.last      = in_end_i;
    push_o          = 1'b0;
    last_val_d      = last_val_q;
    have_prev_d     = have_prev_q;
    pend_d          = pend_q;
    ovf_d           = ovf_q;
    if (accept) begin
      if (in_present_i) begin
        push_o      = 1'b1;
        last_val_d  = in_value_i;
        have_prev_d = 1'b1;
        ovf_d       = 1'b0;
        pend_d      = '0;
      end else if (ovf_q) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_OVF;
        cmd_o.gap  = '0;
      end else if (mode == MODE_FWD) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_FWD;
        pend_d     = '0;
      end else if (in_end_i) begin
        push_o     = 1'b1;
        cmd_o.kind = CMD_END_MISS;
        pend_d     = '0;
      end else if (pend_q < GAP_W'(MAX_GAP)) begin
        pend_d = pend_q + GAP_W'(1);
      end else begin
        // gap too long: the held samples and this one all overflow
        push_o     = 1'b1;
        cmd_o.kind = CMD_OVF;
        pend_d     = '0;
        ovf_d      = 1'b1;
      end
      if (in_end_i) begin
        last_val_d  = '0;
        have_prev_d = 1'b0;
        pend_d      = '0;
        ovf_d       = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_mode_q <= MODE_LINEAR;
      last_val_q  <= '0;
      have_prev_q <= 1'b0;
      pend_q      <= '0;
      ovf_q       <= 1'b0;
    end else begin
      if (cfg_valid_i) begin
        fill_mode_q <= cfg_data_i;
      end
      last_val_q  <= last_val_d;
      have_prev_q <= have_prev_d;
      pend_q      <= pend_d;
      ovf_q       <= ovf_d;
    end
  end

endmodule

FILE: src/sgf_fifo.sv
// ----------------------------------------------------------------------------
// sgf_fifo: short command queue between front and back
// A few entries deep, first word fall through.
// ----------------------------------------------------------------------------
module sgf_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  sgf_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output sgf_pkg::cmd_t data_o
);
  import sgf_pkg::*;

  cmd_t               mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_q;
  logic [PTR_W-1:0]   rd_ptr_q;
  logic [LEVEL_W-1:0] level_q;
  logic               do_push;
  logic               do_pop;

  assign full_o  = level_q == LEVEL_W'(FIFO_DEPTH);
  assign empty_o = level_q == '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      level_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        level_q <= level_q + LEVEL_W'(1);
      end else if (do_pop && !do_push) begin
        level_q <= level_q - LEVEL_W'(1);
      end
    end
  end

endmodule

FILE: src/sgf_div.sv
// ----------------------------------------------------------------------------
// sgf_div: bit-serial restoring divider
// Divides the scaled gap difference by the gap length plus one, one quotient
// bit per cycle, truncating.
// ----------------------------------------------------------------------------
module sgf_div (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [sgf_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  logic [sgf_pkg::DIVISOR_W-1:0]    divisor_i,
  output logic                             done_o,
  output logic [sgf_pkg::VALUE_W-1:0]      quotient_o
);
  import sgf_pkg::*;

  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  div_q;
  logic [DIV_CNT_W-1:0]  cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [DIVISOR_W:0]    trial;
  logic                  fits;

  assign trial      = {rem_q, quo_q[DIVIDEND_W-1]};
  assign fits       = trial >= {1'b0, div_q};
  assign done_o     = done_q;
  // the gap position is below the divisor (gap length plus one), so the quotient fits the value
  assign quotient_o = quo_q[VALUE_W-1:0];

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? DIVISOR_W'(trial - {1'b0, div_q}) : trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= busy_q && !start_i && (cnt_q == DIV_CNT_W'(DIV_STEPS - 1));
      if (start_i) begin
        cnt_q  <= '0;
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q + DIV_CNT_W'(1);
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

endmodule

FILE: src/sgf_back.sv
// ----------------------------------------------------------------------------
// sgf_back: result side of the sample gap filler
// Pops commands, walks the held gap one sample at a time, interpolates
// through the divider in linear mode, and drives the result register.
// ----------------------------------------------------------------------------
module sgf_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          empty_i,
  input  sgf_pkg::cmd_t                 cmd_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [sgf_pkg::VALUE_W-1:0]   out_value_o,
  output logic [1:0]                    out_status_o,
  output logic                          out_run_last_o,
  output logic                          out_eos_o,
  output logic [sgf_pkg::TOTAL_W-1:0]   out_total_o
);
  import sgf_pkg::*;

  localparam logic [2:0] S_LOAD  = 3'd0;
  localparam logic [2:0] S_ITEM  = 3'd1;
  localparam logic [2:0] S_START = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_EMIT  = 3'd4;

  logic [2:0]            state_q, state_d;
  cmd_t                  cmd_q;
  logic [K_W-1:0]        k_q;
  logic [VALUE_W-1:0]    diff_q;
  logic                  up_q;
  logic [DIVIDEND_W-1:0] prod_q;
  logic [VALUE_W-1:0]    res_value_q;
  status_e               res_status_q;
  logic                  res_final_q;
  logic [TOTAL_W-1:0]    total_q, total_d;

  logic                  out_valid_q;
  logic [VALUE_W-1:0]    out_value_q;
  status_e               out_status_q;
  logic                  out_run_last_q;
  logic                  out_eos_q;
  logic [TOTAL_W-1:0]    out_total_q;

  logic                  is_gap;
  logic                  need_div;
  status_e               item_status;
  logic [VALUE_W-1:0]    item_value;
  logic                  out_free;
  logic                  div_done;
  logic [VALUE_W-1:0]    quotient;

  assign is_gap   = k_q <= K_W'(cmd_q.gap);
  assign out_free = !out_valid_q || out_ready_i;
  assign pop_o    = (state_q == S_LOAD) && !empty_i;

  // status and value of the sample at gap position k, or of the closing one
  always_comb begin
    need_div    = 1'b0;
    item_status = ST_MISSING;
    item_value  = '0;
    case (cmd_q.kind)
      CMD_PRESENT: begin
        if (!is_gap) begin
          item_status = ST_ORIG;
          item_value  = cmd_q.next;
        end else begin
          case (cmd_q.mode)
            MODE_FWD: begin
              if (cmd_q.have_prev) begin
                item_status = ST_FILLED;
                item_value  = cmd_q.prev;
              end
            end
            MODE_BWD: begin
              item_status = ST_FILLED;
              item_value  = cmd_q.next;
            end
            default: begin
              need_div = cmd_q.have_prev;
            end
          endcase
        end
      end
      CMD_FWD: begin
        if (cmd_q.have_prev) begin
          item_status = ST_FILLED;
          item_value  = cmd_q.prev;
        end
      end
      CMD_END_MISS: item_status = ST_MISSING;
      CMD_OVF:      item_status = ST_OVERFLOW;
      default:      item_status = ST_MISSING;
    endcase
  end

  always_comb begin
    total_d = total_q;
    if (res_status_q == ST_FILLED && total_q != '1) begin
      total_d = total_q + TOTAL_W'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD:  if (!empty_i) state_d = S_ITEM;
      S_ITEM:  state_d = need_div ? S_START : S_EMIT;
      S_START: state_d = S_DIV;
      S_DIV:   if (div_done) state_d = S_EMIT;
      S_EMIT:  if (out_free) state_d = res_final_q ? S_LOAD : S_ITEM;
      default: state_d = S_LOAD;
    endcase
  end

  sgf_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (state_q == S_START),
    .dividend_i (prod_q),
    .divisor_i  (DIVISOR_W'(cmd_q.gap) + DIVISOR_W'(1)),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cmd_q  <= cmd_i;
      up_q   <= cmd_i.next >= cmd_i.prev;
      diff_q <= (cmd_i.next >= cmd_i.prev) ? cmd_i.next - cmd_i.prev
                                           : cmd_i.prev - cmd_i.next;
    end
    if (state_q == S_ITEM) begin
      prod_q       <= DIVIDEND_W'(diff_q) * DIVIDEND_W'(k_q[GAP_W-1:0]);
      res_value_q  <= item_value;
      res_status_q <= item_status;
      res_final_q  <= !is_gap;
    end
    if (state_q == S_DIV && div_done) begin
      res_value_q  <= up_q ? cmd_q.prev + quotient : cmd_q.prev - quotient;
      res_status_q <= ST_FILLED;
    end
    if (state_q == S_EMIT && out_free) begin
      out_value_q    <= res_value_q;
      out_status_q   <= res_status_q;
      out_run_last_q <= res_final_q;
      out_eos_q      <= res_final_q && cmd_q.last;
      out_total_q    <= total_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_LOAD;
      k_q         <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        k_q <= K_W'(1);
      end
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
        // the fill count starts over after the closing result of a series
        total_q     <= (res_final_q && cmd_q.last) ? '0 : total_d;
        k_q         <= k_q + K_W'(1);
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign out_value_o    = out_value_q;
  assign out_status_o   = out_status_q;
  assign out_run_last_o = out_run_last_q;
  assign out_eos_o      = out_eos_q;
  assign out_total_o    = out_total_q;

endmodule

FILE: src/sample_gap_filler.sv
// Path: a present sample with no held gap goes through the command queue and the
// back's load, item and emit states; a direct fill result via item and emit,
// a linear one also via the multiply and the bit-serial divider (38 steps).
// Throughput: one item a cycle into the 4-entry command queue unless full.
// Reset: asynchronous, active low; clears state, fill mode back to linear.
// ----------------------------------------------------------------------------
// sample_gap_filler: fills missing samples in a Q16.16 series
// Linear, forward or backward fill of gaps held as a count, with gap
// overflow flagging and a running fill count per series.
// ----------------------------------------------------------------------------
module sample_gap_filler (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i,     // fill_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] sample_value
  input  logic        s_axis_tuser,   // [0] present
  input  logic        s_axis_tlast,   // series_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // [31:0] out_value, [47:32] filled_total
  output logic [2:0]  m_axis_tuser,   // [1:0] status, [2] run_last
  output logic        m_axis_tlast    // end_of_series
);
  import sgf_pkg::*;

  logic               push;
  logic               full;
  logic               pop;
  logic               empty;
  cmd_t               cmd_in;
  cmd_t               cmd_out;
  logic [VALUE_W-1:0] out_value;
  logic [1:0]         out_status;
  logic               out_run_last;
  logic [TOTAL_W-1:0] out_total;

  assign cfg_ready_o = 1'b1;

  sgf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_value_i   (s_axis_tdata),
    .in_present_i (s_axis_tuser),
    .in_end_i     (s_axis_tlast),
    .full_i       (full),
    .push_o       (push),
    .cmd_o        (cmd_in)
  );

  sgf_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (cmd_in),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .data_o  (cmd_out)
  );

  sgf_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .cmd_i          (cmd_out),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_value_o    (out_value),
    .out_status_o   (out_status),
    .out_run_last_o (out_run_last),
    .out_eos_o      (m_axis_tlast),
    .out_total_o    (out_total)
  );

  assign m_axis_tdata = {out_total, out_value};
  assign m_axis_tuser = {out_run_last, out_status};

endmodule
